/* hw/rtl/mbcd_pkg.sv */
// Shared types and constants for the multi-button click detector.
// Used by mbcd_cell and multi_button_click_detector_top; depends on nothing else.
package mbcd_pkg;

  localparam int BUTTONS    = 4;
  localparam int TIMER_BITS = 16;
  localparam int COUNT_BITS = 4;

  // Widths of the ports.
  localparam int RAW_BITS       = 4;
  localparam int CFG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int INDEX_OUT_BITS = 2;
  localparam int COUNT_OUT_BITS = 4;

  localparam int BUTTON_IDX_BITS = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
  localparam int CMP_BITS        = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;

  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // Reset values of the configuration registers.
  localparam logic [CFG_BITS-1:0] DEBOUNCE_RESET = CFG_BITS'(20);
  localparam logic [CFG_BITS-1:0] LONG_RESET     = CFG_BITS'(1000);
  localparam logic [CFG_BITS-1:0] GAP_RESET      = CFG_BITS'(300);
  localparam logic                PRESSED_RESET  = 1'b0;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_DEBOUNCE_TICKS    = 2'd0,
    CFG_LONG_PRESS_TICKS  = 2'd1,
    CFG_RELEASE_GAP_TICKS = 2'd2,
    CFG_PRESSED_LEVEL     = 2'd3
  } cfg_index_t;

  typedef enum logic {
    EVT_LONG  = 1'b0,
    EVT_SHORT = 1'b1
  } event_kind_t;

  // Thresholds as the cells see them; zero is already replaced by one.
  typedef struct packed {
    logic [CFG_BITS-1:0] debounce_ticks;
    logic [CFG_BITS-1:0] long_press_ticks;
    logic [CFG_BITS-1:0] release_gap_ticks;
    logic                pressed_level;
  } cell_cfg_t;

  // Event word that travels along the row of cells.
  typedef struct packed {
    logic                       taken;
    logic [BUTTON_IDX_BITS-1:0] index;
    event_kind_t                kind;
    logic [COUNT_BITS-1:0]      count;
  } chain_t;

endpackage

/* hw/rtl/mbcd_cell.sv */
// One button cell: debounce counter, hold timer and click counter.
// Depends on mbcd_pkg; instantiated in a row by multi_button_click_detector_top.
module mbcd_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  logic                                lvl,
  input  logic [mbcd_pkg::BUTTON_IDX_BITS-1:0] cell_index,
  input  mbcd_pkg::cell_cfg_t                 cfg,
  input  mbcd_pkg::chain_t                    chain_in,
  output mbcd_pkg::chain_t                    chain_out
);

  logic                            stable;
  logic                            stable_next;
  logic [mbcd_pkg::COUNT_BITS-1:0] count;
  logic [mbcd_pkg::COUNT_BITS-1:0] count_next;
  logic [mbcd_pkg::TIMER_BITS-1:0] hold;
  logic [mbcd_pkg::TIMER_BITS-1:0] hold_next;
  logic [mbcd_pkg::TIMER_BITS-1:0] deb;
  logic [mbcd_pkg::TIMER_BITS-1:0] deb_next;
  logic [mbcd_pkg::TIMER_BITS-1:0] hold_inc;
  logic [mbcd_pkg::TIMER_BITS-1:0] deb_inc;
  logic                            qualifies;
  logic                            is_pressed;

  always_comb begin
    hold_inc    = (hold == mbcd_pkg::TIMER_MAX) ? hold : hold + 1'b1;
    deb_inc     = (deb == mbcd_pkg::TIMER_MAX) ? deb : deb + 1'b1;
    is_pressed  = (lvl == cfg.pressed_level);
    stable_next = stable;
    count_next  = count;
    hold_next   = hold_inc;
    deb_next    = '0;
    qualifies   = 1'b0;
    chain_out   = chain_in;

    if (lvl != stable) begin
      // Debounce pending: no event is checked on this tick.
      deb_next = deb_inc;
      if (mbcd_pkg::CMP_BITS'(deb_inc) >= mbcd_pkg::CMP_BITS'(cfg.debounce_ticks)) begin
        stable_next = lvl;
        hold_next   = '0;
        deb_next    = '0;
        if (is_pressed && count != mbcd_pkg::COUNT_MAX) begin
          count_next = count + 1'b1;
        end
      end
    end else if (count != '0) begin
      if (is_pressed) begin
        qualifies = mbcd_pkg::CMP_BITS'(hold_inc) >=
                    mbcd_pkg::CMP_BITS'(cfg.long_press_ticks);
      end else begin
        qualifies = mbcd_pkg::CMP_BITS'(hold_inc) >=
                    mbcd_pkg::CMP_BITS'(cfg.release_gap_ticks);
      end
    end

    // A lower button already claimed this tick; this one keeps its count.
    if (qualifies && !chain_in.taken) begin
      chain_out.taken = 1'b1;
      chain_out.index = cell_index;
      if (is_pressed) begin
        chain_out.kind  = mbcd_pkg::EVT_LONG;
        chain_out.count = mbcd_pkg::COUNT_BITS'(1);
      end else begin
        chain_out.kind  = mbcd_pkg::EVT_SHORT;
        chain_out.count = count;
      end
      count_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stable <= ~mbcd_pkg::PRESSED_RESET;
      count  <= '0;
      hold   <= '0;
      deb    <= '0;
    end else if (step) begin
      stable <= stable_next;
      count  <= count_next;
      hold   <= hold_next;
      deb    <= deb_next;
    end
  end

endmodule

/* hw/rtl/multi_button_click_detector_top.sv */
// Top level of the multi-button click detector: config registers, row of
// button cells and the output register. Depends on mbcd_pkg and mbcd_cell.
//
// Usage: every input word is one time tick carrying the raw levels of the
// buttons (raw_levels, bit i is button i). A word is accepted on a rising
// edge with in_valid high and in_stall low. For each tick the block sends
// at most one event word (button_index, event_kind, press_count), taken on
// an edge with out_valid high and out_stall low.
// The event caused by a tick is presented in the cycle after the tick is
// accepted. Throughput: one tick per cycle while in_stall is low; each button
// cell updates its timers in the cycle the tick is taken, and the priority
// among buttons ripples through the row of cells within that cycle.
// When the receiver stalls, the pending event stays in the output register
// and in_stall is raised in the same cycle, so no tick is taken until that
// event leaves; ticks that cause no event still flow only when the output
// register is free or being emptied.
// Reset (rst, synchronous) restores the default thresholds (debounce 20,
// long press 1000, release gap 300, pressed level 0), sets every button to
// released with zero counts and timers, and empties the output register.
// Configuration is written through cfg_write, cfg_index and cfg_data while
// the block is idle; a zero threshold behaves as one.
module multi_button_click_detector_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [mbcd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mbcd_pkg::CFG_BITS-1:0]        cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [mbcd_pkg::RAW_BITS-1:0]        raw_levels,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [mbcd_pkg::INDEX_OUT_BITS-1:0]  button_index,
  output logic                                 event_kind,
  output logic [mbcd_pkg::COUNT_OUT_BITS-1:0]  press_count
);

  mbcd_pkg::cell_cfg_t             cfg;
  mbcd_pkg::chain_t                chain [mbcd_pkg::BUTTONS+1];
  logic [mbcd_pkg::BUTTONS-1:0]    raw_ext;
  logic [mbcd_pkg::CFG_BITS-1:0]   cfg_clamped;
  logic                            step;

  // Thresholds are stored with zero already replaced by one.
  assign cfg_clamped = (cfg_data == '0) ? mbcd_pkg::CFG_BITS'(1) : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks    <= mbcd_pkg::DEBOUNCE_RESET;
      cfg.long_press_ticks  <= mbcd_pkg::LONG_RESET;
      cfg.release_gap_ticks <= mbcd_pkg::GAP_RESET;
      cfg.pressed_level     <= mbcd_pkg::PRESSED_RESET;
    end else if (cfg_write) begin
      case (mbcd_pkg::cfg_index_t'(cfg_index))
        mbcd_pkg::CFG_DEBOUNCE_TICKS:    cfg.debounce_ticks    <= cfg_clamped;
        mbcd_pkg::CFG_LONG_PRESS_TICKS:  cfg.long_press_ticks  <= cfg_clamped;
        mbcd_pkg::CFG_RELEASE_GAP_TICKS: cfg.release_gap_ticks <= cfg_clamped;
        mbcd_pkg::CFG_PRESSED_LEVEL:     cfg.pressed_level     <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // The output register can take a new word when empty or being emptied.
  assign in_stall = out_valid && out_stall;
  assign step     = in_valid && !in_stall;
  assign raw_ext  = mbcd_pkg::BUTTONS'(raw_levels);

  // The head of the row sees no earlier claim.
  assign chain[0] = '0;

  for (genvar i = 0; i < mbcd_pkg::BUTTONS; i++) begin : g_cell
    mbcd_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .step       (step),
      .lvl        (raw_ext[i]),
      .cell_index (mbcd_pkg::BUTTON_IDX_BITS'(i)),
      .cfg        (cfg),
      .chain_in   (chain[i]),
      .chain_out  (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= chain[mbcd_pkg::BUTTONS].taken;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && chain[mbcd_pkg::BUTTONS].taken) begin
      button_index <= mbcd_pkg::INDEX_OUT_BITS'(chain[mbcd_pkg::BUTTONS].index);
      event_kind   <= chain[mbcd_pkg::BUTTONS].kind;
      press_count  <= mbcd_pkg::COUNT_OUT_BITS'(chain[mbcd_pkg::BUTTONS].count);
    end
  end

`ifndef NO_ASSERTIONS
  // An event never reports zero clicks.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> press_count != '0)
    else $error("event word with zero press count");

  // A long press always reports a single click.
  a_long_is_one: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_kind == mbcd_pkg::EVT_LONG) |-> press_count == 1)
    else $error("long press event with count other than one");

  // The output register reflects exactly whether the taken tick produced an event.
  a_step_result: assert property (@(posedge clk) disable iff (rst)
    (step && !rst) |=> out_valid == $past(chain[mbcd_pkg::BUTTONS].taken))
    else $error("output valid does not match the claim from the cell row");

  // A word in the output register is never dropped while the receiver stalls.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(button_index)
                                  && $stable(press_count)))
    else $error("pending event lost or changed under stall");
`endif

endmodule
